// File: design/dcd_pkg.sv
// Shared definitions for the directed cycle detector.
// Holds the request codes, the controller state type and the command and status structs.
// No dependencies.
package dcd_pkg;

	localparam int VERTEX_W = 6;
	localparam int CFG_W    = 7;

	localparam logic CMD_ADD_EDGE = 1'b0;
	localparam logic CMD_EVALUATE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OUTER,
		ST_LOAD,
		ST_SCAN,
		ST_POP,
		ST_DONE
	} dcd_state_t;

	typedef struct packed {
		logic add_edge;
		logic eval_init;
		logic next_v;
		logic start_search;
		logic step_j;
		logic push;
		logic finish;
		logic restore;
		logic mark_cycle;
		logic clear;
		logic emit;
	} dcd_cmd_t;

	typedef struct packed {
		logic outer_done;
		logic v_visited;
		logic scan_end;
		logic edge_bit;
		logic tgt_visited;
		logic tgt_finished;
		logic stack_empty;
	} dcd_sts_t;

endpackage

// File: design/dcd_ctrl.sv
// Controller state machine of the directed cycle detector.
// Sequences the search by issuing commands to the datapath; depends on dcd_pkg.
module dcd_ctrl import dcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_accept,
	input  logic       command,
	input  dcd_sts_t   sts,
	input  logic       res_free,
	output dcd_cmd_t   cmd,
	output dcd_state_t state
);

	dcd_state_t state_q;
	dcd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign state = state_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_accept && command == CMD_EVALUATE) begin
					state_d = ST_OUTER;
				end
			end
			ST_OUTER: begin
				if (sts.outer_done) begin
					state_d = ST_DONE;
				end else if (!sts.v_visited) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_end) begin
					state_d = sts.stack_empty ? ST_OUTER : ST_POP;
				end else if (sts.edge_bit && !sts.tgt_visited) begin
					state_d = ST_LOAD;
				end else if (sts.edge_bit && !sts.tgt_finished) begin
					state_d = ST_DONE;
				end
			end
			ST_POP: begin
				state_d = ST_LOAD;
			end
			ST_DONE: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_accept) begin
					if (command == CMD_EVALUATE) begin
						cmd.eval_init = 1'b1;
					end else begin
						cmd.add_edge = 1'b1;
					end
				end
			end
			ST_OUTER: begin
				if (!sts.outer_done) begin
					cmd.next_v       = 1'b1;
					cmd.start_search = !sts.v_visited;
				end
			end
			ST_LOAD: begin
				cmd = '0;
			end
			ST_SCAN: begin
				if (sts.scan_end) begin
					cmd.finish = 1'b1;
				end else if (!sts.edge_bit) begin
					cmd.step_j = 1'b1;
				end else if (!sts.tgt_visited) begin
					cmd.push = 1'b1;
				end else if (!sts.tgt_finished) begin
					cmd.mark_cycle = 1'b1;
				end else begin
					cmd.step_j = 1'b1;
				end
			end
			ST_POP: begin
				cmd.restore = 1'b1;
			end
			ST_DONE: begin
				if (res_free) begin
					cmd.emit  = 1'b1;
					cmd.clear = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: design/dcd_dpath.sv
// Datapath of the directed cycle detector: adjacency memory, visit marks and search stack.
// Acts on commands from dcd_ctrl and returns status; depends on dcd_pkg.
module dcd_dpath import dcd_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dcd_cmd_t            cmd,
	input  logic [VERTEX_W-1:0] source_vertex,
	input  logic [VERTEX_W-1:0] target_vertex,
	input  logic [CFG_W-1:0]    vertex_count,
	output dcd_sts_t            sts,
	output logic                found,
	output logic                error
);

	localparam int VW    = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int LW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	typedef struct packed {
		logic [VW-1:0]    vertex;
		logic [CNT_W-1:0] next;
	} frame_t;

	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	frame_t                  stk_mem [MAX_VERTICES];

	logic [MAX_VERTICES-1:0] row_valid_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_VERTICES-1:0] finished_q;
	logic [MAX_VERTICES-1:0] rd_row_q;
	logic                    rd_valid_q;
	frame_t                  stk_rd_q;
	logic [CNT_W-1:0]        sp_q;
	logic [CNT_W-1:0]        v_q;
	logic [CNT_W-1:0]        cur_j_q;
	logic [VW-1:0]           cur_u_q;
	logic                    found_q;
	logic                    error_q;

	logic [LW-1:0]           cnt_ext;
	logic [LW-1:0]           max_ext;
	logic [CNT_W-1:0]        live;
	logic                    edge_ok;
	logic [VW-1:0]           s_idx;
	logic [VW-1:0]           t_idx;
	logic [VW-1:0]           v_idx;
	logic [VW-1:0]           j_idx;
	logic [VW-1:0]           stk_raddr;
	logic [MAX_VERTICES-1:0] t_row;
	frame_t                  push_frame;

	// Vertices that exist: the configured count, limited to the matrix size.
	assign cnt_ext = LW'(vertex_count);
	assign max_ext = LW'(MAX_VERTICES);
	assign live    = (cnt_ext < max_ext) ? CNT_W'(cnt_ext) : CNT_W'(max_ext);

	assign edge_ok = (LW'(source_vertex) < LW'(live)) && (LW'(target_vertex) < LW'(live));
	assign s_idx   = VW'(source_vertex);
	assign t_idx   = VW'(target_vertex);
	assign t_row   = MAX_VERTICES'(1) << t_idx;

	assign v_idx     = v_q[VW-1:0];
	assign j_idx     = cur_j_q[VW-1:0];
	assign stk_raddr = sp_q[VW-1:0] - VW'(1);

	assign push_frame.vertex = cur_u_q;
	assign push_frame.next   = cur_j_q + CNT_W'(1);

	assign sts.outer_done   = (v_q >= live);
	assign sts.v_visited    = visited_q[v_idx];
	assign sts.scan_end     = (cur_j_q >= live);
	assign sts.edge_bit     = rd_valid_q & rd_row_q[j_idx];
	assign sts.tgt_visited  = visited_q[j_idx];
	assign sts.tgt_finished = finished_q[j_idx];
	assign sts.stack_empty  = (sp_q == '0);

	assign found = found_q;
	assign error = error_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			visited_q   <= '0;
			finished_q  <= '0;
			sp_q        <= '0;
			v_q         <= '0;
			found_q     <= 1'b0;
			error_q     <= 1'b0;
		end else begin
			if (cmd.add_edge) begin
				if (edge_ok) begin
					row_valid_q[s_idx] <= 1'b1;
				end else begin
					error_q <= 1'b1;
				end
			end
			if (cmd.eval_init) begin
				v_q     <= '0;
				sp_q    <= '0;
				found_q <= 1'b0;
			end
			if (cmd.next_v) begin
				v_q <= v_q + CNT_W'(1);
			end
			if (cmd.start_search) begin
				visited_q[v_idx] <= 1'b1;
				sp_q             <= '0;
			end
			if (cmd.push) begin
				visited_q[j_idx] <= 1'b1;
				sp_q             <= sp_q + CNT_W'(1);
			end
			if (cmd.finish) begin
				finished_q[cur_u_q] <= 1'b1;
			end
			if (cmd.restore) begin
				sp_q <= sp_q - CNT_W'(1);
			end
			if (cmd.mark_cycle) begin
				found_q <= 1'b1;
			end
			if (cmd.clear) begin
				row_valid_q <= '0;
				visited_q   <= '0;
				finished_q  <= '0;
				error_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_search) begin
			cur_u_q <= v_idx;
			cur_j_q <= '0;
		end else if (cmd.push) begin
			cur_u_q <= j_idx;
			cur_j_q <= '0;
		end else if (cmd.restore) begin
			cur_u_q <= stk_rd_q.vertex;
			cur_j_q <= stk_rd_q.next;
		end else if (cmd.step_j) begin
			cur_j_q <= cur_j_q + CNT_W'(1);
		end
	end

	// A row that has not been written since the last clear reads as empty.
	always_ff @(posedge clk) begin
		if (cmd.add_edge && edge_ok) begin
			if (row_valid_q[s_idx]) begin
				adj_mem[s_idx][t_idx] <= 1'b1;
			end else begin
				adj_mem[s_idx] <= t_row;
			end
		end
		rd_row_q   <= adj_mem[cur_u_q];
		rd_valid_q <= row_valid_q[cur_u_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stk_mem[sp_q[VW-1:0]] <= push_frame;
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

endmodule

// File: design/directed_cycle_detector.sv
// Directed cycle detector, top level.
// Joins dcd_ctrl and dcd_dpath, holds the vertex count register and the result register.
// Depends on dcd_pkg, dcd_ctrl and dcd_dpath.
//
// Usage. Requests arrive on the item channel (item_valid, item_stall). A request with
// command set to add-edge writes one bit of the adjacency matrix, so while the block is idle
// edges may stream in at one per cycle. An edge naming a vertex at or above the vertex
// count is dropped and remembered as an error. An evaluate request runs a depth-first
// search over the loaded graph and produces one result (cycle_found, edge_error) on the
// result channel (result_valid, result_stall); add-edge requests produce no result.
// Evaluation holds item_stall high for its whole run: the outer sweep over the vertices,
// a row fetch and a scan-closing step per vertex entered, the scan of each adjacency bit,
// a stack read and a row fetch per return, and the hand-over of the result.
// The search scans one adjacency bit per cycle out of the row memory between row fetches.
// When the search ends the result is placed in the output register, the
// graph is cleared in that same cycle through the per-row valid bits, and the block takes
// requests again. If the receiver stalls, the result is held and edge loads for the next
// graph are still taken; a following evaluation waits in its final cycle until the
// register is free. vertex_count is written through the cfg channel, which is always ready.
// Reset clears the graph and the error flag, empties the result register and sets the
// vertex count to 64.
module directed_cycle_detector import dcd_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    vertex_count,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic                command,
	input  logic [VERTEX_W-1:0] source_vertex,
	input  logic [VERTEX_W-1:0] target_vertex,
	output logic                result_valid,
	input  logic                result_stall,
	output logic                cycle_found,
	output logic                edge_error
);

	logic [CFG_W-1:0] vertex_count_q;
	logic             result_valid_q;
	logic             cycle_found_q;
	logic             edge_error_q;

	logic             item_accept;
	logic             res_free;
	dcd_cmd_t         cmd;
	dcd_sts_t         sts;
	dcd_state_t       state;
	logic             found;
	logic             error;

	// Configuration must be changed only while idle; the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= CFG_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			vertex_count_q <= vertex_count;
		end
	end

	// Requests are taken only while the controller waits for work.
	assign item_stall  = (state != ST_IDLE);
	assign item_accept = item_valid && !item_stall;

	// The result register may be loaded when empty or when its content leaves this cycle.
	assign res_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cycle_found_q <= found;
			edge_error_q  <= error;
		end
	end

	assign result_valid = result_valid_q;
	assign cycle_found  = cycle_found_q;
	assign edge_error   = edge_error_q;

	dcd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_accept (item_accept),
		.command     (command),
		.sts         (sts),
		.res_free    (res_free),
		.cmd         (cmd),
		.state       (state)
	);

	dcd_dpath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.source_vertex (source_vertex),
		.target_vertex (target_vertex),
		.vertex_count  (vertex_count_q),
		.sts           (sts),
		.found         (found),
		.error         (error)
	);

	// The outer sweep only ever runs with the search stack drained.
	a_outer_stack_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state == ST_OUTER |-> sts.stack_empty)
		else $error("outer sweep entered with frames left on the search stack");

	// A back edge ends the search at once and is kept for the result.
	a_cycle_ends_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_cycle |=> state == ST_DONE && found)
		else $error("cycle detection did not end the search");

	// Handing over a result returns the block to taking requests.
	a_emit_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !item_stall && result_valid)
		else $error("result hand-over did not free the request channel");

endmodule
